FILE: rtl/nor_flash_array_controller_assert.svh
// Assertion macros for the flash array controller.
`ifndef NOR_FLASH_ARRAY_CONTROLLER_ASSERT_SVH
`define NOR_FLASH_ARRAY_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define NFAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define NFAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NFAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define NFAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/nfac_pkg.sv
// Types, codes and constants shared by the flash array controller.
`timescale 1ns / 1ps

package nfac_pkg;

    localparam int PAGE_BYTES = 256;
    localparam int PAGE_COUNT = 16;

    localparam int OFFS_W     = $clog2(PAGE_BYTES);
    localparam int PAGE_IDX_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int MEM_ADDR_W = OFFS_W + PAGE_IDX_W;
    localparam int ADDR_IN_W  = 16;
    localparam int PAGE_FULL_W = ADDR_IN_W - OFFS_W;
    localparam int MAP_W      = 16;
    localparam int COUNT_W    = 17;

    localparam logic [MAP_W-1:0]   PAGE_MASK = MAP_W'((33'd1 << PAGE_COUNT) - 33'd1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [7:0]         ERASED_BYTE = 8'hFF;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] UNLOCK_KEY_RESET   = 32'd0;
    localparam logic [15:0] ERASE_LIMIT_RESET  = 16'd10000;
    localparam logic [15:0] FACTORY_BAD_RESET  = 16'd136;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNLOCK_KEY  = 2'd0,
        CFG_ERASE_LIMIT = 2'd1,
        CFG_FACTORY_BAD = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_UNLOCK  = 3'd0,
        OP_ERASE   = 3'd1,
        OP_PROGRAM = 3'd2,
        OP_VERIFY  = 3'd3,
        OP_REINIT  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        RC_OK       = 3'd0,
        RC_MODE     = 3'd1,
        RC_CMD      = 3'd2,
        RC_RANGE    = 3'd3,
        RC_BAD      = 3'd4,
        RC_WORN     = 3'd5,
        RC_MISMATCH = 3'd6
    } rc_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_UNLOCKED = 2'd1,
        MODE_ERROR    = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic [31:0] command_word;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  result_code;
        logic [1:0]  mode;
        logic [7:0]  read_byte;
        logic        locked_flag;
        logic        erasing_flag;
        logic        programming_flag;
        logic        verify_fail_flag;
        logic [15:0] bad_page_map;
    } out_item_t;

endpackage

FILE: rtl/nor_flash_array_controller.sv
// Top level of the NOR flash array controller with per-page wear counting.
//
// Usage: commands enter on in_valid/in_stall/in_item, one result item per command
// leaves on out_valid/out_stall/out_item. cfg_write/cfg_index/cfg_data load the
// unlock key, erase limit and factory bad map; write them only while idle.
// One command is in flight at a time; in_stall is high while it is worked on.
// Unlock, program, verify, refused and unknown commands: the array is read at accept
// and the read-modify-write happens in the next cycle, in the execute state, which
// also loads the result into the output register, or holds it while that is busy;
// a new item is accepted only once the block is back in idle. A successful page
// erase adds a sweep that fills the page with 0xFF, then the hold state; reinitialize
// adds the same over the whole array. The single write port of the byte array makes
// each fill write byte by byte. After reset the same whole-array fill runs with
// in_stall high; configuration writes are taken during it.
// The result sits in an output register: if the receiver stalls, it holds there
// and the next command is still accepted; that command's result then waits
// internally until the output register frees up.
`timescale 1ns / 1ps
`include "nor_flash_array_controller_assert.svh"

module nor_flash_array_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  nfac_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output nfac_pkg::out_item_t                 out_item,
    input  logic                                cfg_write,
    input  logic [nfac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nfac_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import nfac_pkg::*;

    // configuration
    logic [31:0] unlock_key_reg;
    logic [15:0] erase_limit_reg;
    logic [15:0] factory_bad_reg;

    // block state
    state_t                  state_reg;
    mode_t                   mode_reg, mode_next;
    logic                    locked_reg, locked_next;
    logic                    erasing_reg, erasing_next;
    logic                    vfail_reg, vfail_next;
    logic [MAP_W-1:0]        bad_pages_reg, bad_pages_next;
    logic [COUNT_W-1:0]      erase_counts_reg [PAGE_COUNT];

    in_item_t                item_reg;
    out_item_t               result_reg;
    out_item_t               out_item_reg;
    logic                    out_valid_reg;

    logic [MEM_ADDR_W-1:0]   sweep_cnt_reg;
    logic [MEM_ADDR_W-1:0]   sweep_last_reg;
    logic                    sweep_report_reg;

    // command decode
    logic                    accept;
    logic                    out_free;
    logic [PAGE_FULL_W-1:0]  page_full;
    logic [PAGE_IDX_W-1:0]   page_idx;
    logic                    in_range;
    logic [COUNT_W-1:0]      count_cur;
    logic [COUNT_W-1:0]      count_next;
    logic                    count_we;
    logic                    do_reinit;
    logic                    start_page_sweep;
    logic                    do_program;
    rc_t                     rc;
    logic [7:0]              rd_byte;
    out_item_t               result;
    logic                    load_exec;
    logic                    load_hold;

    // array port
    logic                    mem_we;
    logic [MEM_ADDR_W-1:0]   mem_waddr;
    logic [7:0]              mem_wdata;
    logic [7:0]              mem_rdata;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign page_full = item_reg.address[ADDR_IN_W-1:OFFS_W];
    assign page_idx  = page_full[PAGE_IDX_W-1:0];
    assign in_range  = (32'(page_full) < 32'(PAGE_COUNT));
    assign count_cur = erase_counts_reg[page_idx];

    always_comb
    begin
        rc               = RC_OK;
        rd_byte          = 8'd0;
        mode_next        = mode_reg;
        locked_next      = locked_reg;
        erasing_next     = erasing_reg;
        vfail_next       = vfail_reg;
        bad_pages_next   = bad_pages_reg;
        count_next       = count_cur;
        count_we         = 1'b0;
        do_reinit        = 1'b0;
        start_page_sweep = 1'b0;
        do_program       = 1'b0;

        if (item_reg.operation == OP_REINIT)
        begin
            do_reinit      = 1'b1;
            mode_next      = MODE_IDLE;
            locked_next    = 1'b1;
            erasing_next   = 1'b0;
            vfail_next     = 1'b0;
            bad_pages_next = factory_bad_reg & PAGE_MASK;
        end
        else if (item_reg.operation == OP_UNLOCK)
        begin
            if (mode_reg != MODE_IDLE)
            begin
                rc = RC_MODE;
            end
            else if (item_reg.command_word != unlock_key_reg)
            begin
                rc = RC_CMD;
            end
            else
            begin
                mode_next   = MODE_UNLOCKED;
                locked_next = 1'b0;
            end
        end
        else if (!(item_reg.operation inside {OP_ERASE, OP_PROGRAM, OP_VERIFY}))
        begin
            rc = RC_CMD;
        end
        else if (mode_reg != MODE_UNLOCKED)
        begin
            rc = RC_MODE;
        end
        else if (!in_range)
        begin
            rc = RC_RANGE;
        end
        else if (item_reg.operation == OP_VERIFY)
        begin
            rd_byte = mem_rdata;
            if (mem_rdata != item_reg.data_byte)
            begin
                vfail_next = 1'b1;
                rc         = RC_MISMATCH;
            end
        end
        else if (bad_pages_reg[page_idx])
        begin
            rc = RC_BAD;
        end
        else if (item_reg.operation == OP_ERASE)
        begin
            count_we   = 1'b1;
            count_next = (count_cur == COUNT_MAX) ? count_cur : count_cur + 1'b1;
            if (count_next > {1'b0, erase_limit_reg})
            begin
                // worn out: keep the page contents, leave erasing set
                bad_pages_next = bad_pages_reg | (MAP_W'(1) << page_idx);
                mode_next      = MODE_ERROR;
                erasing_next   = 1'b1;
                rc             = RC_WORN;
            end
            else
            begin
                erasing_next     = 1'b0;
                start_page_sweep = 1'b1;
            end
        end
        else
        begin
            do_program = 1'b1;
        end

        result.result_code      = rc;
        result.mode             = mode_next;
        result.read_byte        = rd_byte;
        result.locked_flag      = locked_next;
        result.erasing_flag     = erasing_next;
        result.programming_flag = 1'b0;
        result.verify_fail_flag = vfail_next;
        result.bad_page_map     = bad_pages_next;
    end

    assign load_exec = (state_reg == ST_EXEC) && !do_reinit && !start_page_sweep && out_free;
    assign load_hold = (state_reg == ST_HOLD) && out_free;

    // array write port: fill sweep or program read-modify-write
    always_comb
    begin
        if (state_reg == ST_SWEEP)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_cnt_reg;
            mem_wdata = ERASED_BYTE;
        end
        else
        begin
            mem_we    = (state_reg == ST_EXEC) && do_program;
            mem_waddr = item_reg.address[MEM_ADDR_W-1:0];
            mem_wdata = mem_rdata & item_reg.data_byte;
        end
    end

    nfac_ram #(
        .ADDR_W (MEM_ADDR_W),
        .DATA_W (8)
    ) u_array (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (in_item.address[MEM_ADDR_W-1:0]),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unlock_key_reg  <= UNLOCK_KEY_RESET;
            erase_limit_reg <= ERASE_LIMIT_RESET;
            factory_bad_reg <= FACTORY_BAD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_UNLOCK_KEY:  unlock_key_reg  <= cfg_data;
                CFG_ERASE_LIMIT: erase_limit_reg <= cfg_data[15:0];
                CFG_FACTORY_BAD: factory_bad_reg <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_SWEEP;
            sweep_cnt_reg    <= '0;
            sweep_last_reg   <= '1;
            sweep_report_reg <= 1'b0;
            mode_reg         <= MODE_IDLE;
            locked_reg       <= 1'b1;
            erasing_reg      <= 1'b0;
            vfail_reg        <= 1'b0;
            bad_pages_reg    <= FACTORY_BAD_RESET & PAGE_MASK;
            for (int p = 0; p < PAGE_COUNT; p++)
            begin
                erase_counts_reg[p] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    mode_reg      <= mode_next;
                    locked_reg    <= locked_next;
                    erasing_reg   <= erasing_next;
                    vfail_reg     <= vfail_next;
                    bad_pages_reg <= bad_pages_next;
                    if (do_reinit)
                    begin
                        for (int p = 0; p < PAGE_COUNT; p++)
                        begin
                            erase_counts_reg[p] <= '0;
                        end
                        sweep_cnt_reg    <= '0;
                        sweep_last_reg   <= '1;
                        sweep_report_reg <= 1'b1;
                        state_reg        <= ST_SWEEP;
                    end
                    else
                    begin
                        if (count_we)
                        begin
                            erase_counts_reg[page_idx] <= count_next;
                        end
                        if (start_page_sweep)
                        begin
                            sweep_cnt_reg    <= {page_idx, {OFFS_W{1'b0}}};
                            sweep_last_reg   <= {page_idx, {OFFS_W{1'b1}}};
                            sweep_report_reg <= 1'b1;
                            state_reg        <= ST_SWEEP;
                        end
                        else if (out_free)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_SWEEP:
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                    if (sweep_cnt_reg == sweep_last_reg)
                    begin
                        // the fill after reset has no item to report
                        state_reg <= sweep_report_reg ? ST_HOLD : ST_IDLE;
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        if (state_reg == ST_EXEC)
        begin
            result_reg <= result;
        end
        if (load_exec)
        begin
            out_item_reg <= result;
        end
        else if (load_hold)
        begin
            out_item_reg <= result_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_exec || load_hold)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `NFAC_ASSERT_NXT(a_accept_to_exec, clk, rst_n, accept, (state_reg == ST_EXEC),
                     "accepted item did not enter execution")
    `NFAC_ASSERT_IMP(a_no_write_idle, clk, rst_n, (state_reg == ST_IDLE), !mem_we,
                     "array written while idle")
    `NFAC_ASSERT_IMP(a_sweep_fill, clk, rst_n, (state_reg == ST_SWEEP),
                     (mem_we && (mem_wdata == ERASED_BYTE)),
                     "fill sweep not writing erased bytes")
    `NFAC_ASSERT_IMP(a_error_has_bad, clk, rst_n, (mode_reg == MODE_ERROR),
                     (bad_pages_reg != '0), "error mode without a bad page")

endmodule

FILE: rtl/nfac_ram.sv
// Simple dual-port byte array with registered read data.
`timescale 1ns / 1ps

module nfac_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sim/nor_flash_array_checker.sv
// Checker that predicts and compares the flash array controller's result items.
`timescale 1ns / 1ps

module nor_flash_array_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  nfac_pkg::in_item_t              in_item,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  nfac_pkg::out_item_t             out_item,
    input  logic                            cfg_write,
    input  logic [nfac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nfac_pkg::CFG_DATA_W-1:0] cfg_data,
    output int unsigned                     mismatches,
    output int unsigned                     pending,
    output int unsigned                     results_checked,
    output int unsigned                     pages_worn
);

    import nfac_pkg::*;

    localparam int ARRAY_BYTES = PAGE_BYTES * PAGE_COUNT;

    // shadow copies of the registers
    logic [31:0]        key_shadow;
    logic [15:0]        limit_shadow;
    logic [15:0]        factory_shadow;

    // shadow copy of the array state
    mode_t              mode_now;
    logic [7:0]         cells [ARRAY_BYTES];
    logic [COUNT_W-1:0] wear [PAGE_COUNT];
    logic [MAP_W-1:0]   bad_map;
    logic               locked;
    logic               erasing;
    logic               verify_failed;

    out_item_t          predicted_replies [$];

    task automatic report(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] checker: result item %0d: %s", $time, results_checked, what);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
    endtask

    task automatic restore_array();
        mode_now = MODE_IDLE;
        foreach (cells[i])
            cells[i] = ERASED_BYTE;
        foreach (wear[p])
            wear[p] = '0;
        bad_map       = factory_shadow & PAGE_MASK;
        locked        = 1'b1;
        erasing       = 1'b0;
        verify_failed = 1'b0;
    endtask

    task automatic run_flash_command(input in_item_t cmd, output out_item_t res);
        logic [PAGE_FULL_W-1:0] page;
        logic [PAGE_IDX_W-1:0]  pidx;
        logic [OFFS_W-1:0]      offs;
        logic [MEM_ADDR_W-1:0]  cell_idx;
        rc_t                    code;
        logic [7:0]             stored;
        page     = cmd.address[ADDR_IN_W-1:OFFS_W];
        pidx     = page[PAGE_IDX_W-1:0];
        offs     = cmd.address[OFFS_W-1:0];
        cell_idx = {pidx, offs};
        code     = RC_OK;
        stored   = 8'h00;
        if (cmd.operation == OP_REINIT)
        begin
            restore_array();
        end
        else if (cmd.operation == OP_UNLOCK)
        begin
            if (mode_now != MODE_IDLE)
                code = RC_MODE;
            else if (cmd.command_word != key_shadow)
                code = RC_CMD;
            else
            begin
                mode_now = MODE_UNLOCKED;
                locked   = 1'b0;
            end
        end
        else if (cmd.operation > OP_REINIT)
        begin
            code = RC_CMD;
        end
        else if (mode_now != MODE_UNLOCKED)
        begin
            code = RC_MODE;
        end
        else if (page >= PAGE_COUNT)
        begin
            code = RC_RANGE;
        end
        else if (cmd.operation == OP_VERIFY)
        begin
            // bad pages still read back
            stored = cells[cell_idx];
            if (stored != cmd.data_byte)
            begin
                verify_failed = 1'b1;
                code          = RC_MISMATCH;
            end
        end
        else if (bad_map[pidx])
        begin
            code = RC_BAD;
        end
        else if (cmd.operation == OP_ERASE)
        begin
            erasing = 1'b1;
            if (wear[pidx] != COUNT_MAX)
                wear[pidx] = wear[pidx] + 1'b1;
            if (wear[pidx] > {1'b0, limit_shadow})
            begin
                // worn out: keep contents, leave the erasing bit up
                bad_map[pidx] = 1'b1;
                mode_now      = MODE_ERROR;
                code          = RC_WORN;
                pages_worn++;
            end
            else
            begin
                for (int i = 0; i < PAGE_BYTES; i++)
                    cells[{pidx, OFFS_W'(i)}] = ERASED_BYTE;
                erasing = 1'b0;
            end
        end
        else
        begin
            cells[cell_idx] = cells[cell_idx] & cmd.data_byte;
        end
        res.result_code      = code;
        res.mode             = mode_now;
        res.read_byte        = stored;
        res.locked_flag      = locked;
        res.erasing_flag     = erasing;
        res.programming_flag = 1'b0;
        res.verify_fail_flag = verify_failed;
        res.bad_page_map     = bad_map;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            key_shadow      = UNLOCK_KEY_RESET;
            limit_shadow    = ERASE_LIMIT_RESET;
            factory_shadow  = FACTORY_BAD_RESET;
            restore_array();
            predicted_replies.delete();
            mismatches      = 0;
            results_checked = 0;
            pages_worn      = 0;
            pending <= 0;
        end
        else
        begin
            // compare before predicting: a new item never leaves in the edge it enters
            if (out_valid && !out_stall)
            begin
                if (predicted_replies.size() == 0)
                begin
                    report("result item arrived with no command outstanding");
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    compare_field("result_code", 32'(out_item.result_code),
                                  32'(want.result_code));
                    compare_field("mode", 32'(out_item.mode), 32'(want.mode));
                    compare_field("read_byte", 32'(out_item.read_byte), 32'(want.read_byte));
                    compare_field("locked_flag", 32'(out_item.locked_flag),
                                  32'(want.locked_flag));
                    compare_field("erasing_flag", 32'(out_item.erasing_flag),
                                  32'(want.erasing_flag));
                    compare_field("programming_flag", 32'(out_item.programming_flag),
                                  32'(want.programming_flag));
                    compare_field("verify_fail_flag", 32'(out_item.verify_fail_flag),
                                  32'(want.verify_fail_flag));
                    compare_field("bad_page_map", 32'(out_item.bad_page_map),
                                  32'(want.bad_page_map));
                end
                results_checked++;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_UNLOCK_KEY:  key_shadow     = cfg_data;
                    CFG_ERASE_LIMIT: limit_shadow   = cfg_data[15:0];
                    CFG_FACTORY_BAD: factory_shadow = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                run_flash_command(in_item, want);
                predicted_replies.push_back(want);
            end
            pending <= predicted_replies.size();
        end
    end

endmodule

FILE: sim/nor_flash_array_controller_tb.sv
// Testbench top for the flash array controller: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module nor_flash_array_controller_tb;
    import nfac_pkg::*;

    // the limit leaves room for the slowest plausible run, whose time goes mostly into whole-array fills
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int ARRAY_BYTES = PAGE_BYTES * PAGE_COUNT;

    localparam logic [2:0]           OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0]           OP_LAST_UNUSED  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE       = 2'd3;

    typedef enum int {
        FLOW_FREE,
        FLOW_CHOPPY,
        FLOW_CLOGGED,
        FLOW_LIGHT
    } flow_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned results_checked;
    int unsigned pages_worn;

    int unsigned cycle_count   = 0;
    int unsigned commands_sent = 0;
    int unsigned burst_left    = 0;
    logic [31:0] cur_key       = UNLOCK_KEY_RESET;
    logic [15:0] last_addr     = 16'h0000;
    logic [7:0]  last_data     = ERASED_BYTE;

    flow_t       flow        = FLOW_FREE;
    int unsigned flow_left   = 0;

    nor_flash_array_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nor_flash_array_checker watcher (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_item        (out_item),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .pages_worn      (pages_worn)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk) cycle_count++;
        $display("nor_flash_array_controller verification failed");
        $finish;
    end

    // receiver back-pressure: switch between flow styles every so often
    always @(posedge clk)
    begin
        if (flow_left == 0)
        begin
            flow      = flow_t'($urandom_range(0, 3));
            flow_left = $urandom_range(20, 120);
        end
        else
        begin
            flow_left--;
        end
        case (flow)
            FLOW_FREE:    out_stall <= 1'b0;
            FLOW_CHOPPY:  out_stall <= ($urandom_range(0, 1) == 1);
            FLOW_CLOGGED: out_stall <= ($urandom_range(0, 3) != 0);
            default:      out_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic in_item_t flash_cmd(input logic [2:0] op, input logic [15:0] addr,
                                           input logic [7:0] data, input logic [31:0] word);
        in_item_t it;
        it.operation    = op;
        it.address      = addr;
        it.data_byte    = data;
        it.command_word = word;
        return it;
    endfunction

    // send one item; bursts of random length with random gaps between them
    task automatic issue(input in_item_t it);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        commands_sent++;
    endtask

    // drop valid and hold until every outstanding result item has come back
    task automatic quiesce();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic load_settings(input logic [31:0] key, input logic [15:0] limit,
                                 input logic [15:0] factory_map);
        logic [CFG_DATA_W-1:0] noise;
        noise = $urandom();
        cfg_write <= 1'b1;
        cfg_index <= CFG_UNLOCK_KEY;
        cfg_data  <= key;
        @(posedge clk);
        cfg_index <= CFG_ERASE_LIMIT;
        cfg_data  <= {noise[31:16], limit};
        @(posedge clk);
        cfg_index <= CFG_FACTORY_BAD;
        cfg_data  <= {noise[15:0], factory_map};
        @(posedge clk);
        // unused index must change nothing
        cfg_index <= CFG_SPARE;
        cfg_data  <= noise;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_key = key;
    endtask

    function automatic logic [15:0] erase_target();
        int unsigned page;
        // lean on the low pages so wear builds up
        page = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3)
                                           : $urandom_range(0, PAGE_COUNT - 1);
        return 16'(page * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
    endfunction

    // open with an optional reinit and an unlock, then a run of mixed commands
    task automatic flash_session(input int unsigned len, input bit fresh);
        int unsigned roll;
        logic [15:0] addr;
        logic [7:0]  data;
        if (fresh || $urandom_range(0, 1) == 1)
            issue(flash_cmd(OP_REINIT, 16'($urandom()), 8'($urandom()), $urandom()));
        issue(flash_cmd(OP_UNLOCK, 16'($urandom()), 8'($urandom()),
                        ($urandom_range(0, 9) == 0) ? $urandom() : cur_key));
        repeat (len)
        begin
            roll = $urandom_range(0, 99);
            addr = 16'($urandom_range(0, ARRAY_BYTES - 1));
            data = 8'($urandom());
            if (roll < 30)
            begin
                issue(flash_cmd(OP_PROGRAM, addr, data, $urandom()));
                last_addr = addr;
                last_data = data;
            end
            else if (roll < 55)
            begin
                case ($urandom_range(0, 3))
                    0, 1:    issue(flash_cmd(OP_VERIFY, last_addr, last_data, $urandom()));
                    2:       issue(flash_cmd(OP_VERIFY, addr, ERASED_BYTE, $urandom()));
                    default: issue(flash_cmd(OP_VERIFY, addr, data, $urandom()));
                endcase
            end
            else if (roll < 73)
            begin
                issue(flash_cmd(OP_ERASE, erase_target(), data, $urandom()));
            end
            else if (roll < 80)
            begin
                issue(flash_cmd(OP_UNLOCK, addr, data,
                                ($urandom_range(0, 1) == 1) ? cur_key : $urandom()));
            end
            else if (roll < 86)
            begin
                issue(flash_cmd(3'($urandom_range(int'(OP_FIRST_UNUSED), int'(OP_LAST_UNUSED))),
                                16'($urandom()), data, $urandom()));
            end
            else if (roll < 95)
            begin
                issue(flash_cmd(3'($urandom_range(int'(OP_ERASE), int'(OP_VERIFY))),
                                16'($urandom_range(ARRAY_BYTES, 16'hFFFF)), data, $urandom()));
            end
            else
            begin
                issue(flash_cmd(OP_REINIT, addr, data, $urandom()));
                issue(flash_cmd(OP_UNLOCK, addr, data, cur_key));
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: key zero, pages 3 and 7 bad
        issue(flash_cmd(OP_VERIFY, 16'h0000, 8'hFF, 32'h0));
        issue(flash_cmd(OP_UNLOCK, 16'h0000, 8'h00, 32'hFFFF_FFFF));
        issue(flash_cmd(OP_FIRST_UNUSED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
        issue(flash_cmd(OP_UNLOCK, 16'h0000, 8'h00, 32'h0));
        issue(flash_cmd(OP_UNLOCK, 16'h0000, 8'h00, 32'h0));
        issue(flash_cmd(OP_PROGRAM, 16'h0000, 8'h00, 32'h0));
        issue(flash_cmd(OP_VERIFY, 16'h0000, 8'h00, 32'h0));
        issue(flash_cmd(OP_VERIFY, 16'h0000, 8'hFF, 32'h0));
        issue(flash_cmd(OP_PROGRAM, 16'h0FFF, 8'hA5, 32'h0));
        issue(flash_cmd(OP_PROGRAM, 16'h0FFF, 8'h5A, 32'h0));
        issue(flash_cmd(OP_VERIFY, 16'h0FFF, 8'h00, 32'h0));
        issue(flash_cmd(OP_ERASE, 16'h1000, 8'h00, 32'h0));
        issue(flash_cmd(OP_PROGRAM, 16'hFFFF, 8'h00, 32'h0));
        issue(flash_cmd(OP_ERASE, 16'h0300, 8'h00, 32'h0));
        issue(flash_cmd(OP_PROGRAM, 16'h07FF, 8'h00, 32'h0));
        issue(flash_cmd(OP_VERIFY, 16'h0380, 8'hFF, 32'h0));
        issue(flash_cmd(OP_ERASE, 16'h0000, 8'h00, 32'h0));
        issue(flash_cmd(OP_LAST_UNUSED - 3'd1, 16'h0000, 8'h00, 32'h0));
        issue(flash_cmd(OP_REINIT, 16'h0000, 8'h00, 32'h0));
        issue(flash_cmd(OP_ERASE, 16'h0100, 8'h00, 32'h0));

        // all-ones key, one erase allowed per page, no factory bad pages
        quiesce();
        load_settings(32'hFFFF_FFFF, 16'd1, 16'h0000);
        issue(flash_cmd(OP_REINIT, 16'h0000, 8'h00, 32'h0));
        issue(flash_cmd(OP_UNLOCK, 16'h0000, 8'h00, cur_key));
        issue(flash_cmd(OP_ERASE, 16'h0500, 8'h00, 32'h0));
        issue(flash_cmd(OP_ERASE, 16'h05AB, 8'h00, 32'h0));
        issue(flash_cmd(OP_PROGRAM, 16'h0500, 8'h00, 32'h0));
        issue(flash_cmd(OP_UNLOCK, 16'h0000, 8'h00, cur_key));
        flash_session($urandom_range(8, 24), 1'b1);
        while (commands_sent < 200)
            flash_session($urandom_range(8, 24), 1'b0);

        // widest limit, every page bad from the factory
        quiesce();
        load_settings($urandom(), 16'hFFFF, 16'hFFFF);
        flash_session($urandom_range(8, 24), 1'b1);
        while (commands_sent < 320)
            flash_session($urandom_range(8, 24), 1'b0);

        // small random limit and random bad map
        quiesce();
        load_settings($urandom(), 16'($urandom_range(2, 6)), 16'($urandom()));
        flash_session($urandom_range(8, 24), 1'b1);
        while (commands_sent < 620)
        begin
            flash_session($urandom_range(8, 24), 1'b0);
            if ($urandom_range(0, 4) == 0)
                quiesce();
        end

        quiesce();
        repeat (16) @(posedge clk);
        $display("covered %0d commands under four register settings, %0d result items compared",
                 commands_sent, results_checked);
        $display("pages worn out along the way: %0d", pages_worn);
        if (mismatches == 0)
            $display("nor_flash_array_controller verification clean");
        else
            $display("nor_flash_array_controller verification failed");
        $finish;
    end

endmodule
